// ===== sv/hhlp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the HTTP header line parser.
// Depends on nothing; used by the front, the command queue, the back end and the top level.
package hhlp_pkg;

   localparam int NAME_ADDR_W = 6;   // covers a name store of up to 64 entries
   localparam int CMD_DEPTH   = 4;
   localparam int CMD_PTR_W   = 2;
   localparam int CMD_CNT_W   = 3;

   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_STORE,
      OP_DRAIN,
      OP_VALUE,
      OP_HEND,
      OP_DONE
   } op_kind_type;

   typedef enum logic [1:0] {
      KIND_NAME,
      KIND_VALUE,
      KIND_HEND,
      KIND_DONE
   } item_kind_type;

   // addr: store address for OP_STORE, run length for OP_DRAIN
   // hidx: header index, or header count for OP_DONE
   typedef struct packed {
      op_kind_type            kind;
      logic [7:0]             data;
      logic [NAME_ADDR_W-1:0] addr;
      logic [7:0]             hidx;
   } op_type;

   // op0 carries the work of a held CR, op1 the work of the word itself
   typedef struct packed {
      op_type op0;
      op_type op1;
   } cmd_type;

endpackage

// ===== sv/hhlp_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts request words, tracks the line state and turns words into commands.
// Depends on hhlp_pkg.
module hhlp_front #(
   parameter int NAME_BYTES  = 32,
   parameter int VALUE_BYTES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic              req_tlast,
   input  logic [7:0]        max_headers,
   output logic              cmd_push,
   output hhlp_pkg::cmd_type cmd_data,
   input  logic              cmd_full
);

   localparam int NLW = $clog2(NAME_BYTES);
   localparam int VLW = $clog2(VALUE_BYTES);

   typedef enum logic [1:0] {
      PH_NAME,
      PH_SKIP,
      PH_VALUE
   } phase_type;

   typedef struct packed {
      phase_type      phase;
      logic [NLW-1:0] name_len;
      logic [VLW-1:0] value_len;
      logic           two;
   } line_type;

   typedef struct packed {
      line_type         st;
      hhlp_pkg::op_type op;
   } step_type;

   localparam line_type LINE_CLEAR = '0;

   function automatic step_type line_byte(input line_type st, input logic [7:0] c,
                                          input logic [7:0] hf);
      step_type   r;
      logic [7:0] lc;
      r    = '0;
      r.st = st;
      lc   = (c >= hhlp_pkg::CH_UPPER_A && c <= hhlp_pkg::CH_UPPER_Z) ?
             c + hhlp_pkg::CASE_SHIFT : c;
      if (st.phase != PH_NAME || st.name_len != '0) begin
         r.st.two = 1'b1;
      end
      if (st.phase == PH_NAME) begin
         if (c == hhlp_pkg::CH_COLON) begin
            r.st.phase = PH_SKIP;
            if (st.name_len != '0) begin
               r.op.kind = hhlp_pkg::OP_DRAIN;
               r.op.addr = hhlp_pkg::NAME_ADDR_W'(st.name_len);
               r.op.hidx = hf;
            end
         end else if (st.name_len != NLW'(NAME_BYTES - 1)) begin
            r.op.kind     = hhlp_pkg::OP_STORE;
            r.op.addr     = hhlp_pkg::NAME_ADDR_W'(st.name_len);
            r.op.data     = lc;
            r.st.name_len = st.name_len + NLW'(1);
         end
      end else if (!(st.phase == PH_SKIP &&
                     (c == hhlp_pkg::CH_SPACE || c == hhlp_pkg::CH_TAB))) begin
         r.st.phase = PH_VALUE;
         if (st.value_len != VLW'(VALUE_BYTES - 1)) begin
            r.op.kind      = hhlp_pkg::OP_VALUE;
            r.op.data      = c;
            r.op.hidx      = hf;
            r.st.value_len = st.value_len + VLW'(1);
         end
      end
      return r;
   endfunction

   line_type   line_ff, line_in;
   logic [7:0] hf_ff, hf_in;
   logic       held_ff, held_in;
   logic       limit_ff, limit_in;

   step_type   step_cr, step_word;
   line_type   line_mid;
   logic [7:0] hf_inc;
   logic       accept;

   assign req_tready = !cmd_full;
   assign accept     = req_tvalid && req_tready;
   assign cmd_push   = accept && (cmd_data.op0.kind != hhlp_pkg::OP_NOP ||
                                  cmd_data.op1.kind != hhlp_pkg::OP_NOP);

   always_comb begin
      step_cr   = line_byte(line_ff, hhlp_pkg::CH_CR, hf_ff);
      line_mid  = held_ff ? step_cr.st : line_ff;
      step_word = line_byte(line_mid, req_tdata, hf_ff);
      hf_inc    = hf_ff + 8'd1;

      line_in  = line_ff;
      hf_in    = hf_ff;
      held_in  = held_ff;
      limit_in = limit_ff;
      cmd_data = '0;

      if (!limit_ff) begin
         if (held_ff && req_tdata == hhlp_pkg::CH_LF) begin
            held_in = 1'b0;
            if (line_ff.phase != PH_NAME && line_ff.two) begin
               cmd_data.op0.kind = hhlp_pkg::OP_HEND;
               cmd_data.op0.hidx = hf_ff;
               hf_in             = hf_inc;
               limit_in          = (hf_inc >= max_headers);
            end
            line_in = LINE_CLEAR;
         end else if (!req_tlast) begin
            // flush a lone CR as an ordinary line byte first
            if (held_ff) begin
               held_in      = 1'b0;
               line_in      = step_cr.st;
               cmd_data.op0 = step_cr.op;
            end
            if (req_tdata == hhlp_pkg::CH_CR) begin
               held_in = 1'b1;
            end else begin
               line_in      = step_word.st;
               cmd_data.op1 = step_word.op;
            end
         end
      end

      if (req_tlast) begin
         cmd_data.op1      = '0;
         cmd_data.op1.kind = hhlp_pkg::OP_DONE;
         cmd_data.op1.hidx = hf_in;
         line_in           = LINE_CLEAR;
         hf_in             = 8'd0;
         held_in           = 1'b0;
         limit_in          = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff  <= LINE_CLEAR;
         hf_ff    <= 8'd0;
         held_ff  <= 1'b0;
         limit_ff <= 1'b0;
      end else if (accept) begin
         line_ff  <= line_in;
         hf_ff    <= hf_in;
         held_ff  <= held_in;
         limit_ff <= limit_in;
      end
   end

endmodule

// ===== sv/hhlp_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the front end and the back end, head shown ahead of the pop.
// Depends on hhlp_pkg.
module hhlp_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hhlp_pkg::cmd_type push_cmd,
   output logic              full,
   output logic              head_valid,
   output hhlp_pkg::cmd_type head_cmd,
   input  logic              pop
);

   hhlp_pkg::cmd_type                  entries_ff [hhlp_pkg::CMD_DEPTH];
   logic [hhlp_pkg::CMD_PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [hhlp_pkg::CMD_CNT_W-1:0]     count_ff, count_in;

   assign full       = (count_ff == hhlp_pkg::CMD_CNT_W'(hhlp_pkg::CMD_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entries_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + hhlp_pkg::CMD_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - hhlp_pkg::CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + hhlp_pkg::CMD_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + hhlp_pkg::CMD_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== sv/hhlp_back.sv =====
`timescale 1ns / 1ps
// Back end: carries out queued commands, holds the name store and drives the result register.
// Depends on hhlp_pkg.
module hhlp_back #(
   parameter int NAME_BYTES = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  hhlp_pkg::cmd_type head_cmd,
   output logic              pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [23:0]       rsp_tdata,   // [7:0] out_byte, [15:8] header_index,
                                          // [23:16] header_count
   output logic [1:0]        rsp_tuser,   // [1:0] item_kind
   output logic              rsp_tlast
);

   localparam int NLW = $clog2(NAME_BYTES);

   logic [7:0]     name_mem [NAME_BYTES-1];

   logic           sel_ff, sel_in;
   logic [NLW-1:0] cnt_ff, cnt_in;
   logic           rsp_tvalid_ff;
   logic [1:0]     rsp_kind_ff;
   logic [7:0]     rsp_byte_ff, rsp_index_ff, rsp_count_ff;
   logic           rsp_last_ff;

   hhlp_pkg::op_type        cur;
   hhlp_pkg::item_kind_type kind;
   logic                    at_op1, op1_emits, cur_emits, out_free;
   logic                    step, op_end, emit, finish, mem_we, run_end;

   always_comb begin
      at_op1    = sel_ff || head_cmd.op0.kind == hhlp_pkg::OP_NOP;
      cur       = at_op1 ? head_cmd.op1 : head_cmd.op0;
      op1_emits = head_cmd.op1.kind == hhlp_pkg::OP_DRAIN ||
                  head_cmd.op1.kind == hhlp_pkg::OP_VALUE ||
                  head_cmd.op1.kind == hhlp_pkg::OP_HEND  ||
                  head_cmd.op1.kind == hhlp_pkg::OP_DONE;
      out_free  = !rsp_tvalid_ff || rsp_tready;

      unique case (cur.kind)
         hhlp_pkg::OP_NOP, hhlp_pkg::OP_STORE: begin
            cur_emits = 1'b0;
            op_end    = 1'b1;
            kind      = hhlp_pkg::KIND_NAME;
         end
         hhlp_pkg::OP_DRAIN: begin
            cur_emits = 1'b1;
            op_end    = (cnt_ff == cur.addr[NLW-1:0] - NLW'(1));
            kind      = hhlp_pkg::KIND_NAME;
         end
         hhlp_pkg::OP_VALUE: begin
            cur_emits = 1'b1;
            op_end    = 1'b1;
            kind      = hhlp_pkg::KIND_VALUE;
         end
         hhlp_pkg::OP_HEND: begin
            cur_emits = 1'b1;
            op_end    = 1'b1;
            kind      = hhlp_pkg::KIND_HEND;
         end
         hhlp_pkg::OP_DONE: begin
            cur_emits = 1'b1;
            op_end    = 1'b1;
            kind      = hhlp_pkg::KIND_DONE;
         end
         default: begin
            cur_emits = 1'b0;
            op_end    = 1'b1;
            kind      = hhlp_pkg::KIND_NAME;
         end
      endcase

      step    = head_valid && (!cur_emits || out_free);
      emit    = step && cur_emits;
      mem_we  = step && cur.kind == hhlp_pkg::OP_STORE;
      finish  = step && op_end;
      pop     = finish && (at_op1 || head_cmd.op1.kind == hhlp_pkg::OP_NOP);
      // the word's run closes on its final result
      run_end = op_end && (at_op1 || !op1_emits);

      sel_in = sel_ff;
      if (finish) begin
         sel_in = !pop;
      end
      cnt_in = cnt_ff;
      if (emit && cur.kind == hhlp_pkg::OP_DRAIN) begin
         cnt_in = op_end ? '0 : cnt_ff + NLW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff        <= 1'b0;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
         cnt_ff <= cnt_in;
         if (emit) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         name_mem[cur.addr[NLW-1:0]] <= cur.data;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_kind_ff  <= kind;
         rsp_byte_ff  <= (cur.kind == hhlp_pkg::OP_DRAIN) ? name_mem[cnt_ff] : cur.data;
         rsp_index_ff <= (cur.kind == hhlp_pkg::OP_DONE) ? 8'd0 : cur.hidx;
         rsp_count_ff <= (cur.kind == hhlp_pkg::OP_DONE) ? cur.hidx : 8'd0;
         rsp_last_ff  <= run_end;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_count_ff, rsp_index_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== sv/http_header_line_parser_top.sv =====
`timescale 1ns / 1ps
// Top level of the HTTP header line parser: front end, command queue, back end, csr register.
// Depends on hhlp_pkg, hhlp_front, hhlp_cmd_fifo and hhlp_back.
//
//   channel  direction  word                          end marker
//   req_     in         data_byte                     tlast = end_of_request
//   rsp_     out        out_byte, index, count/kind   tlast = run_last
//   csr_     in         max_headers (8 bits)          -
//
// The front end takes one request word per cycle while the command queue has room.
// The back end handles each result and each buffered name byte as a separate step, so a
// name byte is handled twice; the colon drains the name store one byte a cycle while rsp_ is free.
// Synchronous reset clears all control state and sets max_headers to 16.
// A stalled rsp_ side fills the four-entry queue, after which req_tready drops.
module http_header_line_parser_top #(
   parameter int NAME_BYTES  = 32,
   parameter int VALUE_BYTES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] out_byte, [15:8] header_index,
                                    // [23:16] header_count
   output logic [1:0]  rsp_tuser,   // [1:0] item_kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   logic [7:0]        max_headers_ff;
   logic              cmd_push, cmd_full, head_valid, cmd_pop;
   hhlp_pkg::cmd_type cmd_wr, head_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_headers_ff <= 8'd16;
      end else if (csr_valid && csr_ready) begin
         max_headers_ff <= csr_data;
      end
   end

   hhlp_front #(
      .NAME_BYTES  (NAME_BYTES),
      .VALUE_BYTES (VALUE_BYTES)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .max_headers (max_headers_ff),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_wr),
      .cmd_full    (cmd_full)
   );

   hhlp_cmd_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd_wr),
      .full       (cmd_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (cmd_pop)
   );

   hhlp_back #(
      .NAME_BYTES (NAME_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("command pushed into a full queue");

   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> head_valid)
      else $error("command popped from an empty queue");

   a_done_closes_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == hhlp_pkg::KIND_DONE) |-> rsp_tlast)
      else $error("request-done word without tlast");

   a_idle_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown straight after reset");

endmodule
